/* hw/rtl/gqvg_pkg.sv */
package gqvg_pkg;

    localparam int POS_W     = 24;
    localparam int U_W       = 17;
    localparam int GW_W      = 8;
    localparam int SCALE_W   = 12;
    localparam int DX_W      = GW_W + SCALE_W;
    localparam int SUM_W     = POS_W + 2;
    localparam int VERT_CNT_W = 3;

    localparam logic [U_W-1:0]        U_ONE       = 17'h10000;
    localparam logic [7:0]            CODE_SPACE  = 8'd32;
    localparam logic [SCALE_W-1:0]    SCALE_ONE   = 12'd256;
    localparam logic [VERT_CNT_W-1:0] VERT_LAST   = 3'd5;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_BEGIN = 2'd1,
        MODE_DRAW  = 2'd2
    } mode_t;

    // what an item does once it reaches the pen stage
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_SPACE = 2'd2,
        OP_DRAW  = 2'd3
    } op_t;

    typedef struct packed {
        logic [U_W-1:0]  left_u;
        logic [U_W-1:0]  right_u;
        logic [GW_W-1:0] width;
    } glyph_entry_t;

    function automatic logic [U_W-1:0] clamp_u(input logic [U_W-1:0] v);
        return (v > U_ONE) ? U_ONE : v;
    endfunction

    // saturate a two's complement sum to the signed position range
    function automatic logic [POS_W-1:0] sat_pos(input logic [SUM_W-1:0] v);
        logic [POS_W-1:0] r;
        if (!v[SUM_W-1] && (v[SUM_W-2:POS_W-1] != 2'b00)) begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end else if (v[SUM_W-1] && (v[SUM_W-2:POS_W-1] != 2'b11)) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/gqvg_ram.sv */
module gqvg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/glyph_quad_vertex_generator_unit.sv */
// glyph quad vertex generator
// input channel s_*: one item per handshake. mode load writes one glyph table
// entry (u values clamped to 1.0), mode begin sets pen x, pen y and scale,
// mode draw lays out one character. a space moves the pen by 3*scale; a
// drawable code sends six vertices on m_* (two triangles, bl tr tl bl br tr),
// with m_last_vertex high on the sixth. other codes and mode 3 do nothing.
// a character's first vertex passes stage 1, stage 2, the quad buffer and the
// output register to m_*; the rest follow one per cycle while m_ready is high.
// load, begin, space and ignored items are accepted one per cycle while
// s_ready is high; a drawn character is paced by the single vertex output
// register, which sends one vertex per cycle. the next character is decoded
// and its glyph entry read from the table ram while the current one is still
// being sent. when m_ready is low the output register holds its vertex, the
// quad buffer and pipeline fill, and s_ready drops until the receiver resumes.
// reset (aresetn low, synchronous) sets pen to 0,0 and scale to 1.0 and drops
// all pending vertices; the glyph table ram is not cleared and must be loaded
// before its entries are drawn.
module glyph_quad_vertex_generator_unit
    import gqvg_pkg::*;
#(
    parameter int GLYPH_COUNT = 95
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_mode,
    input  logic [6:0]                s_load_index,
    input  logic [16:0]               s_load_left,
    input  logic [16:0]               s_load_right,
    input  logic [7:0]                s_load_width,
    input  logic signed [23:0]        s_start_x,
    input  logic signed [23:0]        s_start_y,
    input  logic [11:0]               s_scale_in,
    input  logic [7:0]                s_char_code,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [23:0]        m_vert_x,
    output logic signed [23:0]        m_vert_y,
    output logic [16:0]               m_tex_u,
    output logic                      m_tex_v,
    output logic                      m_last_vertex
);

    localparam int AW = $clog2(GLYPH_COUNT > 1 ? GLYPH_COUNT : 2);
    localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);

    // pipeline control
    logic adv;
    logic accept;
    logic o_free;
    logic emit;
    logic q_free;

    // input decode
    logic [7:0]   glyph_idx;
    logic         code_ok;
    logic         load_ok;
    op_t          op_in;
    glyph_entry_t wr_entry;
    glyph_entry_t rd_entry;

    // stage 1: glyph entry read in flight
    op_t              s1_op_reg;
    logic [POS_W-1:0] s1_x_reg;
    logic [POS_W-1:0] s1_y_reg;
    logic [SCALE_W-1:0] s1_sc_reg;
    logic [SCALE_W-1:0] cur_scale_reg;

    // stage 2: width times scale done, pen update
    op_t              s2_op_reg;
    logic [POS_W-1:0] s2_x_reg;
    logic [POS_W-1:0] s2_y_reg;
    logic [SCALE_W-1:0] s2_sc_reg;
    logic [DX_W-1:0]  s2_dx_reg;
    logic [U_W-1:0]   s2_ul_reg;
    logic [U_W-1:0]   s2_ur_reg;
    logic [DX_W-1:0]  dx_next;

    logic [POS_W-1:0] pen_x_reg;
    logic [POS_W-1:0] pen_y_reg;
    logic [SUM_W-1:0] pen_x_ext;
    logic [SUM_W-1:0] pen_y_ext;
    logic [SUM_W-1:0] sum_xr;
    logic [SUM_W-1:0] sum_yb;
    logic [SUM_W-1:0] sum_adv;
    logic [SUM_W-1:0] sum_space;

    // quad buffer
    logic                  q_valid_reg;
    logic [VERT_CNT_W-1:0] q_cnt_reg;
    logic [POS_W-1:0]      q_xl_reg;
    logic [POS_W-1:0]      q_xr_reg;
    logic [POS_W-1:0]      q_yt_reg;
    logic [POS_W-1:0]      q_yb_reg;
    logic [U_W-1:0]        q_ul_reg;
    logic [U_W-1:0]        q_ur_reg;
    logic                  vert_right;
    logic                  vert_bottom;

    // output register
    logic              m_valid_reg;
    logic [POS_W-1:0]  o_x_reg;
    logic [POS_W-1:0]  o_y_reg;
    logic [U_W-1:0]    o_u_reg;
    logic              o_v_reg;
    logic              o_last_reg;

    assign o_free = !m_valid_reg || m_ready;
    assign emit   = q_valid_reg && o_free;
    assign q_free = !q_valid_reg || (emit && (q_cnt_reg == VERT_LAST));
    assign adv    = !((s2_op_reg == OP_DRAW) && !q_free);
    assign s_ready = adv;
    assign accept = s_valid && adv;

    assign glyph_idx = s_char_code - CODE_SPACE;
    assign code_ok   = (s_char_code >= CODE_SPACE) && ({1'b0, glyph_idx} < GLYPH_LIMIT);
    assign load_ok   = ({2'b00, s_load_index} < GLYPH_LIMIT);

    always_comb begin
        op_in = OP_NONE;
        unique case (s_mode)
            MODE_BEGIN: op_in = OP_BEGIN;
            MODE_DRAW: begin
                if (code_ok) begin
                    op_in = (glyph_idx == 8'd0) ? OP_SPACE : OP_DRAW;
                end
            end
            default: op_in = OP_NONE;
        endcase
    end

    assign wr_entry.left_u  = clamp_u(s_load_left);
    assign wr_entry.right_u = clamp_u(s_load_right);
    assign wr_entry.width   = s_load_width;

    gqvg_ram #(
        .WIDTH ($bits(glyph_entry_t)),
        .DEPTH (GLYPH_COUNT)
    ) u_glyph_ram (
        .aclk    (aclk),
        .wr_en   (accept && (s_mode == MODE_LOAD) && load_ok),
        .wr_addr (AW'(s_load_index)),
        .wr_data (wr_entry),
        .rd_en   (accept),
        .rd_addr (AW'(glyph_idx)),
        .rd_data (rd_entry)
    );

    assign dx_next = {{SCALE_W{1'b0}}, rd_entry.width} * {{GW_W{1'b0}}, s1_sc_reg};

    assign pen_x_ext = {{2{pen_x_reg[POS_W-1]}}, pen_x_reg};
    assign pen_y_ext = {{2{pen_y_reg[POS_W-1]}}, pen_y_reg};
    assign sum_xr    = pen_x_ext + {{(SUM_W-DX_W){1'b0}}, s2_dx_reg};
    assign sum_adv   = sum_xr + {{(SUM_W-SCALE_W){1'b0}}, s2_sc_reg};
    assign sum_yb    = pen_y_ext - {{(SUM_W-SCALE_W-4){1'b0}}, s2_sc_reg, 4'b0000};
    assign sum_space = pen_x_ext + {{(SUM_W-SCALE_W){1'b0}}, s2_sc_reg}
                     + {{(SUM_W-SCALE_W-1){1'b0}}, s2_sc_reg, 1'b0};

    // scale is taken at the input so each item carries the scale in force
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_op_reg     <= OP_NONE;
            s2_op_reg     <= OP_NONE;
            cur_scale_reg <= SCALE_ONE;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
        end else if (adv) begin
            s1_op_reg <= accept ? op_in : OP_NONE;
            s2_op_reg <= s1_op_reg;
            if (accept && (s_mode == MODE_BEGIN)) begin
                cur_scale_reg <= s_scale_in;
            end
            case (s2_op_reg)
                OP_BEGIN: begin
                    pen_x_reg <= s2_x_reg;
                    pen_y_reg <= s2_y_reg;
                end
                OP_SPACE: pen_x_reg <= sat_pos(sum_space);
                OP_DRAW:  pen_x_reg <= sat_pos(sum_adv);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_x_reg  <= s_start_x;
            s1_y_reg  <= s_start_y;
            s1_sc_reg <= cur_scale_reg;
            s2_x_reg  <= s1_x_reg;
            s2_y_reg  <= s1_y_reg;
            s2_sc_reg <= s1_sc_reg;
            s2_dx_reg <= dx_next;
            s2_ul_reg <= rd_entry.left_u;
            s2_ur_reg <= rd_entry.right_u;
        end
    end

    // quad buffer: a new quad may land in the cycle its predecessor's last vertex leaves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
            q_cnt_reg   <= '0;
        end else if (adv && (s2_op_reg == OP_DRAW)) begin
            q_valid_reg <= 1'b1;
            q_cnt_reg   <= '0;
        end else if (emit) begin
            q_cnt_reg <= q_cnt_reg + 1'b1;
            if (q_cnt_reg == VERT_LAST) begin
                q_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && (s2_op_reg == OP_DRAW)) begin
            q_xl_reg <= pen_x_reg;
            q_xr_reg <= sat_pos(sum_xr);
            q_yt_reg <= pen_y_reg;
            q_yb_reg <= sat_pos(sum_yb);
            q_ul_reg <= s2_ul_reg;
            q_ur_reg <= s2_ur_reg;
        end
    end

    // vertex order bl tr tl bl br tr
    always_comb begin
        case (q_cnt_reg)
            3'd0:    {vert_right, vert_bottom} = 2'b01;
            3'd1:    {vert_right, vert_bottom} = 2'b10;
            3'd2:    {vert_right, vert_bottom} = 2'b00;
            3'd3:    {vert_right, vert_bottom} = 2'b01;
            3'd4:    {vert_right, vert_bottom} = 2'b11;
            default: {vert_right, vert_bottom} = 2'b10;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            o_x_reg    <= vert_right ? q_xr_reg : q_xl_reg;
            o_y_reg    <= vert_bottom ? q_yb_reg : q_yt_reg;
            o_u_reg    <= vert_right ? q_ur_reg : q_ul_reg;
            o_v_reg    <= vert_bottom;
            o_last_reg <= (q_cnt_reg == VERT_LAST);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_vert_x      = o_x_reg;
    assign m_vert_y      = o_y_reg;
    assign m_tex_u       = o_u_reg;
    assign m_tex_v       = o_v_reg;
    assign m_last_vertex = o_last_reg;

endmodule

/* hw/rtl/gqvg_checker.sv */
module gqvg_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [23:0] m_vert_x,
    input logic signed [23:0] m_vert_y,
    input logic [16:0]        m_tex_u,
    input logic               m_tex_v,
    input logic               m_last_vertex
);

    // a stalled vertex holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vert_x) && $stable(m_vert_y)
            && $stable(m_tex_u) && $stable(m_tex_v) && $stable(m_last_vertex))
        else $error("vertex changed while stalled");

    // the closing vertex of a quad is top right; only its top edge is checked
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_vertex |-> !m_tex_v)
        else $error("last vertex not on top edge");

    // vertices of one glyph leave without gaps
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_vertex |=> m_valid)
        else $error("gap inside a glyph");

    // reset drops pending vertices
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("vertex pending after reset");

endmodule

bind glyph_quad_vertex_generator_unit gqvg_checker u_gqvg_checker (.*);

/* bench/glyph_quad_vertex_generator_unit_test.sv */
module glyph_quad_vertex_generator_unit_test
    import gqvg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GLYPHS = 95;
    localparam int RAND_ITEMS = 245;
    localparam int LONG_HOLD = 300;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int POS_HI = 8388607;
    localparam int POS_LO = -8388608;

    typedef struct packed {
        logic [1:0]  mode;
        logic [6:0]  load_index;
        logic [16:0] load_left;
        logic [16:0] load_right;
        logic [7:0]  load_width;
        logic [23:0] start_x;
        logic [23:0] start_y;
        logic [11:0] scale_in;
        logic [7:0]  char_code;
    } glyph_item_t;

    typedef struct packed {
        logic [23:0] xl;
        logic [23:0] xr;
        logic [23:0] yt;
        logic [23:0] yb;
        logic [16:0] ul;
        logic [16:0] ur;
    } quad_t;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [16:0] u;
        logic        v;
        logic        last;
    } vertex_t;

    typedef struct packed {
        glyph_item_t it;
        logic        typed;
        quad_t       q;
    } table_row_t;

    localparam quad_t NO_QUAD = '0;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_mode;
    logic [6:0]          s_load_index;
    logic [16:0]         s_load_left;
    logic [16:0]         s_load_right;
    logic [7:0]          s_load_width;
    logic signed [23:0]  s_start_x;
    logic signed [23:0]  s_start_y;
    logic [11:0]         s_scale_in;
    logic [7:0]          s_char_code;
    logic                m_valid;
    logic                m_ready;
    logic signed [23:0]  m_vert_x;
    logic signed [23:0]  m_vert_y;
    logic [16:0]         m_tex_u;
    logic                m_tex_v;
    logic                m_last_vertex;

    glyph_quad_vertex_generator_unit #(
        .GLYPH_COUNT(GLYPHS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_load_index  (s_load_index),
        .s_load_left   (s_load_left),
        .s_load_right  (s_load_right),
        .s_load_width  (s_load_width),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_scale_in    (s_scale_in),
        .s_char_code   (s_char_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_vert_x      (m_vert_x),
        .m_vert_y      (m_vert_y),
        .m_tex_u       (m_tex_u),
        .m_tex_v       (m_tex_v),
        .m_last_vertex (m_last_vertex)
    );

    // layout state mirrored from the block
    logic [16:0] left_tab [GLYPHS];
    logic [16:0] right_tab [GLYPHS];
    logic [7:0]  width_tab [GLYPHS];
    bit          loaded [GLYPHS];
    int          loaded_q [$];
    logic [23:0] pen_x;
    logic [23:0] pen_y;
    logic [11:0] cur_scale;

    vertex_t vertex_q [$];

    int errors = 0;
    int n_accepted = 0;
    int n_glyphs = 0;
    int n_spaces = 0;
    int n_loads = 0;
    int n_begins = 0;
    int n_ignored = 0;
    int n_verts = 0;
    bit hold_done = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [23:0] clip_pos(input longint v);
        if (v > POS_HI) return 24'h7FFFFF;
        if (v < POS_LO) return 24'h800000;
        return 24'(v);
    endfunction

    function automatic vertex_t vtx(input logic [23:0] x, input logic [23:0] y,
                                    input logic [16:0] u, input logic v, input logic last);
        vertex_t r;
        r.x = x;
        r.y = y;
        r.u = u;
        r.v = v;
        r.last = last;
        return r;
    endfunction

    function automatic quad_t mkq(input int xl, input int xr, input int yt, input int yb,
                                  input int ul, input int ur);
        quad_t q;
        q.xl = 24'(xl);
        q.xr = 24'(xr);
        q.yt = 24'(yt);
        q.yb = 24'(yb);
        q.ul = 17'(ul);
        q.ur = 17'(ur);
        return q;
    endfunction

    // unused fields carry random noise
    function automatic glyph_item_t noise_item(input logic [1:0] mode);
        glyph_item_t it;
        it.mode = mode;
        it.load_index = 7'($urandom);
        it.load_left = 17'($urandom);
        it.load_right = 17'($urandom);
        it.load_width = 8'($urandom);
        it.start_x = 24'($urandom);
        it.start_y = 24'($urandom);
        it.scale_in = 12'($urandom);
        it.char_code = 8'($urandom);
        return it;
    endfunction

    function automatic glyph_item_t mk_load(input int idx, input int l, input int r, input int w);
        glyph_item_t it;
        it = noise_item(MODE_LOAD);
        it.load_index = 7'(idx);
        it.load_left = 17'(l);
        it.load_right = 17'(r);
        it.load_width = 8'(w);
        return it;
    endfunction

    function automatic glyph_item_t mk_begin(input int x, input int y, input int s);
        glyph_item_t it;
        it = noise_item(MODE_BEGIN);
        it.start_x = 24'(x);
        it.start_y = 24'(y);
        it.scale_in = 12'(s);
        return it;
    endfunction

    function automatic glyph_item_t mk_draw(input int code);
        glyph_item_t it;
        it = noise_item(MODE_DRAW);
        it.char_code = 8'(code);
        return it;
    endfunction

    function automatic int rand_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return int'($urandom_range(0, 2097152)) - 1048576;
        if (r == 6) return POS_HI - int'($urandom_range(0, 300000));
        if (r == 7) return POS_LO + int'($urandom_range(0, 300000));
        return int'($signed(24'($urandom)));
    endfunction

    function automatic int rand_scale();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(64, 768);
        if (r == 7) return 0;
        if (r == 8) return 4095;
        return $urandom_range(0, 4095);
    endfunction

    function automatic int pick_code();
        if (loaded_q.size() == 0 || $urandom_range(0, 99) < 15) return int'(CODE_SPACE);
        return int'(CODE_SPACE) + loaded_q[$urandom_range(0, loaded_q.size() - 1)];
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // update the layout state for one item and queue the vertices it yields
    task automatic layout_item(input glyph_item_t it, input bit typed, input quad_t tq);
        longint sc;
        longint dx;
        int     g;
        int     idx;
        quad_t  q;
        sc = longint'(cur_scale);
        idx = int'(it.load_index);
        g = int'(it.char_code) - int'(CODE_SPACE);
        if (it.mode == MODE_LOAD && idx < GLYPHS) begin
            left_tab[idx] = (it.load_left > U_ONE) ? U_ONE : it.load_left;
            right_tab[idx] = (it.load_right > U_ONE) ? U_ONE : it.load_right;
            width_tab[idx] = it.load_width;
            if (!loaded[idx] && idx != 0) loaded_q.push_back(idx);
            loaded[idx] = 1'b1;
            n_loads++;
        end else if (it.mode == MODE_BEGIN) begin
            pen_x = it.start_x;
            pen_y = it.start_y;
            cur_scale = it.scale_in;
            n_begins++;
        end else if (it.mode == MODE_DRAW && g == 0) begin
            pen_x = clip_pos(longint'($signed(pen_x)) + 3 * sc);
            n_spaces++;
        end else if (it.mode == MODE_DRAW && g > 0 && g < GLYPHS) begin
            dx = longint'(width_tab[g]) * sc;
            q.xl = pen_x;
            q.xr = clip_pos(longint'($signed(pen_x)) + dx);
            q.yt = pen_y;
            q.yb = clip_pos(longint'($signed(pen_y)) - 16 * sc);
            q.ul = left_tab[g];
            q.ur = right_tab[g];
            if (typed) q = tq;
            vertex_q.push_back(vtx(q.xl, q.yb, q.ul, 1'b1, 1'b0));
            vertex_q.push_back(vtx(q.xr, q.yt, q.ur, 1'b0, 1'b0));
            vertex_q.push_back(vtx(q.xl, q.yt, q.ul, 1'b0, 1'b0));
            vertex_q.push_back(vtx(q.xl, q.yb, q.ul, 1'b1, 1'b0));
            vertex_q.push_back(vtx(q.xr, q.yb, q.ur, 1'b1, 1'b0));
            vertex_q.push_back(vtx(q.xr, q.yt, q.ur, 1'b0, 1'b1));
            pen_x = clip_pos(longint'($signed(pen_x)) + dx + sc);
            n_glyphs++;
        end else begin
            n_ignored++;
        end
    endtask

    task automatic offer_item(input glyph_item_t it, input bit typed, input quad_t tq,
                              input bit quiet);
        int gap;
        s_valid <= 1'b1;
        s_mode <= it.mode;
        s_load_index <= it.load_index;
        s_load_left <= it.load_left;
        s_load_right <= it.load_right;
        s_load_width <= it.load_width;
        s_start_x <= it.start_x;
        s_start_y <= it.start_y;
        s_scale_in <= it.scale_in;
        s_char_code <= it.char_code;
        do @(posedge aclk); while (!s_ready);
        layout_item(it, typed, tq);
        n_accepted++;
        gap = pick_gap(quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        vertex_t w;
        if (aresetn && m_valid && m_ready) begin
            n_verts++;
            if (vertex_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected vertex, expected none, actual x=%0d y=%0d u=%0d",
                         $time, m_vert_x, m_vert_y, m_tex_u);
            end else begin
                w = vertex_q.pop_front();
                check_field("vert_x", $signed(w.x), m_vert_x);
                check_field("vert_y", $signed(w.y), m_vert_y);
                check_field("tex_u", w.u, m_tex_u);
                check_field("tex_v", w.v, m_tex_v);
                check_field("last_vertex", w.last, m_last_vertex);
            end
        end
    end

    // receiver: random holds, quiet stretches, and one long stall to back up the input
    initial begin : receiver
        int gap;
        int run;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!hold_done && n_verts >= 60) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1'b1;
            end
            m_ready <= 1'b1;
            run = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 6);
            repeat (run) @(posedge aclk);
            gap = pick_gap(1'b0);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        table_row_t  rows [$];
        glyph_item_t it;
        int          i;
        int          n;
        int          r;
        int          len;
        bit          paused;
        bit          quiet;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_mode <= MODE_LOAD;
        s_load_index <= '0;
        s_load_left <= '0;
        s_load_right <= '0;
        s_load_width <= '0;
        s_start_x <= '0;
        s_start_y <= '0;
        s_scale_in <= '0;
        s_char_code <= '0;
        pen_x = '0;
        pen_y = '0;
        cur_scale = SCALE_ONE;
        for (i = 0; i < GLYPHS; i++) begin
            left_tab[i] = '0;
            right_tab[i] = '0;
            width_tab[i] = '0;
            loaded[i] = 1'b0;
        end

        // after reset pen is 0,0 and scale is one
        rows.push_back({mk_load(0, 100, 200, 3), 1'b0, NO_QUAD});
        rows.push_back({mk_load(1, 0, 65536, 8), 1'b0, NO_QUAD});
        rows.push_back({mk_draw(33), 1'b1, mkq(0, 2048, 0, -4096, 0, 65536)});
        // u above one is clamped when stored
        rows.push_back({mk_load(94, 131071, 70000, 255), 1'b0, NO_QUAD});
        rows.push_back({mk_draw(126), 1'b1, mkq(2304, 67584, 0, -4096, 65536, 65536)});
        rows.push_back({mk_draw(32), 1'b0, NO_QUAD});
        // codes out of range, unused mode, loads past the table
        rows.push_back({mk_draw(31), 1'b0, NO_QUAD});
        rows.push_back({mk_draw(127), 1'b0, NO_QUAD});
        rows.push_back({mk_draw(255), 1'b0, NO_QUAD});
        rows.push_back({mk_draw(0), 1'b0, NO_QUAD});
        rows.push_back({noise_item(MODE_UNUSED), 1'b0, NO_QUAD});
        rows.push_back({mk_load(95, 5, 5, 1), 1'b0, NO_QUAD});
        rows.push_back({mk_load(127, 7, 7, 2), 1'b0, NO_QUAD});
        rows.push_back({mk_draw(33), 1'b0, NO_QUAD});
        // saturation at both ends
        rows.push_back({mk_begin(POS_HI, POS_LO, 4095), 1'b0, NO_QUAD});
        rows.push_back({mk_draw(126), 1'b1,
                        mkq(POS_HI, POS_HI, POS_LO, POS_LO, 65536, 65536)});
        rows.push_back({mk_draw(32), 1'b0, NO_QUAD});
        rows.push_back({mk_draw(33), 1'b0, NO_QUAD});
        rows.push_back({mk_begin(POS_LO, POS_HI, 0), 1'b0, NO_QUAD});
        rows.push_back({mk_draw(33), 1'b1, mkq(POS_LO, POS_LO, POS_HI, POS_HI, 0, 65536)});
        rows.push_back({mk_load(1, 65536, 0, 0), 1'b0, NO_QUAD});
        rows.push_back({mk_draw(33), 1'b0, NO_QUAD});
        rows.push_back({mk_begin(POS_LO, 0, 4095), 1'b0, NO_QUAD});
        rows.push_back({mk_draw(126), 1'b0, NO_QUAD});
        rows.push_back({mk_begin(0, 0, 256), 1'b0, NO_QUAD});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < rows.size(); i++) offer_item(rows[i].it, rows[i].typed, rows[i].q, 1'b0);

        n = 0;
        paused = 1'b0;
        while (n < RAND_ITEMS) begin
            quiet = ((n / 40) % 4) == 3;
            if (!paused && n >= RAND_ITEMS / 2) begin
                // let the block drain completely before going on
                s_valid <= 1'b0;
                while (vertex_q.size() != 0) @(posedge aclk);
                repeat (10) @(posedge aclk);
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 12) begin
                i = $urandom_range(0, 99);
                i = (i < 85) ? $urandom_range(1, 94) : (i < 90) ? 0 : $urandom_range(95, 127);
                it = ($urandom_range(0, 4) == 0)
                    ? mk_load(i, $urandom_range(0, 131071), $urandom_range(0, 131071),
                              $urandom_range(0, 255))
                    : mk_load(i, $urandom_range(0, 65536), $urandom_range(0, 65536),
                              $urandom_range(0, 255));
                offer_item(it, 1'b0, NO_QUAD, quiet);
                n++;
            end else if (r < 90) begin
                offer_item(mk_begin(rand_pos(), rand_pos(), rand_scale()), 1'b0, NO_QUAD, quiet);
                n++;
                len = $urandom_range(1, 8);
                repeat (len) begin
                    offer_item(mk_draw(pick_code()), 1'b0, NO_QUAD, quiet);
                    n++;
                end
            end else if (r < 95) begin
                offer_item(noise_item(MODE_UNUSED), 1'b0, NO_QUAD, quiet);
            end else begin
                i = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31) : $urandom_range(127, 255);
                offer_item(mk_draw(i), 1'b0, NO_QUAD, quiet);
            end
        end
        s_valid <= 1'b0;

        while (vertex_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d items: %0d loads, %0d begins, %0d spaces, %0d ignored,",
                 n_accepted, n_loads, n_begins, n_spaces, n_ignored);
        $display("and %0d drawn glyphs giving %0d checked vertices", n_glyphs, n_verts);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* glyph_quad_vertex_generator_unit.f */
hw/rtl/gqvg_pkg.sv
hw/rtl/gqvg_ram.sv
hw/rtl/glyph_quad_vertex_generator_unit.sv
hw/rtl/gqvg_checker.sv
bench/glyph_quad_vertex_generator_unit_test.sv
